// File: rtl/pol_pkg.sv
// shared types and constants for the positional ordered list core
// no dependencies; imported by every module of the block
package pol_pkg;

  // list geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int VAL_W    = 32;
  localparam int CNT_OUT_W = 5;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // stream widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_READ    = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_DEL_FST = 3'd2,
    CMD_DEL_LST = 3'd3,
    CMD_DEL_POS = 3'd4
  } cmd_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;  // input transfer happens this cycle
    logic step;    // emit next element of a read out
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;  // output register can take a new result
    logic multi;     // offered item is a read out of more than one element
    logic at_last;   // read out index sits on the final element
  } dp_sts_t;

endpackage

// File: rtl/pol_ctrl.sv
// controller state machine for the positional ordered list core
// depends on pol_pkg for the command and status structs
module pol_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  pol_pkg::dp_sts_t   dp_sts,
  output pol_pkg::ctrl_cmd_t ctrl_cmd
);
  import pol_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // handshake and commands
  assign in_tready       = (state_r == S_IDLE) && dp_sts.out_free;
  assign ctrl_cmd.accept = in_tvalid && in_tready;
  assign ctrl_cmd.step   = (state_r == S_READ) && dp_sts.out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (ctrl_cmd.accept && dp_sts.multi) state_nxt = S_READ;
      end
      S_READ: begin
        if (ctrl_cmd.step && dp_sts.at_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/pol_dp.sv
// datapath for the positional ordered list core: element cells, count,
// read out index and output register; depends on pol_pkg
module pol_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [pol_pkg::CMD_W-1:0]      in_tuser,
  input  logic [pol_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [pol_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [pol_pkg::STATUS_W-1:0]   out_tuser,
  output logic                           out_tlast,
  input  pol_pkg::ctrl_cmd_t             ctrl_cmd,
  output pol_pkg::dp_sts_t               dp_sts
);
  import pol_pkg::*;

  logic signed [VAL_W-1:0] cells_r [CAPACITY];
  logic signed [VAL_W-1:0] cells_nxt [CAPACITY];
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;

  logic                    out_vld_r, out_vld_nxt;
  logic signed [VAL_W-1:0] out_data_r, out_data_nxt;
  status_t                 out_st_r, out_st_nxt;
  logic [CNT_OUT_W-1:0]    out_cnt_r, out_cnt_nxt;
  logic                    out_last_r, out_last_nxt;

  cmd_t                    cmd;
  logic [POS_W-1:0]        pos;
  logic signed [VAL_W-1:0] val;
  logic [CMP_W-1:0]        pos_c, cnt_c;
  logic                    empty, full;

  // input unpacking
  assign cmd   = cmd_t'(in_tuser);
  assign pos   = in_tdata[POS_W-1:0];
  assign val   = in_tdata[POS_W +: VAL_W];
  assign pos_c = CMP_W'(pos);
  assign cnt_c = CMP_W'(count_r);
  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(CAPACITY));

  // status to controller
  assign dp_sts.out_free = !out_vld_r || out_tready;
  assign dp_sts.multi    = (cmd == CMD_READ) && (count_r > CNT_W'(1));
  assign dp_sts.at_last  = (CNT_W'(idx_r) == count_r - CNT_W'(1));

  // command execution: parallel shift of all cells and result selection
  always_comb begin
    logic             do_ins;
    logic             do_del;
    logic [IDX_W-1:0] k;
    status_t          st;

    do_ins       = 1'b0;
    do_del       = 1'b0;
    k            = '0;
    st           = ST_OK;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    out_data_nxt = out_data_r;
    out_st_nxt   = out_st_r;
    out_last_nxt = out_last_r;
    out_vld_nxt  = out_vld_r && !out_tready;

    // check and decode the accepted command
    if (ctrl_cmd.accept) begin
      case (cmd)
        CMD_INSERT: begin
          if (pos == '0 || pos_c > cnt_c + CMP_W'(1)) begin
            st = ST_BADPOS;
          end else if (full) begin
            st = ST_FULL;
          end else begin
            do_ins = 1'b1;
            k      = IDX_W'(pos - POS_W'(1));
          end
        end
        CMD_DEL_FST: begin
          if (empty) begin
            st = ST_EMPTY;
          end else begin
            do_del = 1'b1;
            k      = '0;
          end
        end
        CMD_DEL_LST: begin
          if (empty) begin
            st = ST_EMPTY;
          end else begin
            do_del = 1'b1;
            k      = IDX_W'(count_r - CNT_W'(1));
          end
        end
        CMD_DEL_POS: begin
          if (empty) begin
            st = ST_EMPTY;
          end else if (pos == '0 || pos_c > cnt_c) begin
            st = ST_BADPOS;
          end else begin
            do_del = 1'b1;
            k      = IDX_W'(pos - POS_W'(1));
          end
        end
        default: st = ST_OK;
      endcase
    end

    // cell moves, each cell looks only at its neighbours
    for (int i = 0; i < CAPACITY; i++) begin
      cells_nxt[i] = cells_r[i];
      if (do_ins) begin
        if (IDX_W'(i) == k) begin
          cells_nxt[i] = val;
        end else if (i > 0 && IDX_W'(i) > k) begin
          cells_nxt[i] = cells_r[(i > 0) ? i - 1 : 0];
        end
      end else if (do_del) begin
        if (i < CAPACITY - 1 && IDX_W'(i) >= k) begin
          cells_nxt[i] = cells_r[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end

    if (do_ins) count_nxt = count_r + CNT_W'(1);
    if (do_del) count_nxt = count_r - CNT_W'(1);

    // result for an accepted item
    if (ctrl_cmd.accept) begin
      out_vld_nxt = 1'b1;
      if (cmd == CMD_READ) begin
        idx_nxt = IDX_W'(1);
        if (empty) begin
          out_data_nxt = '0;
          out_st_nxt   = ST_EMPTY;
          out_last_nxt = 1'b1;
        end else begin
          out_data_nxt = cells_r[0];
          out_st_nxt   = ST_OK;
          out_last_nxt = (count_r == CNT_W'(1));
        end
      end else begin
        out_data_nxt = '0;
        out_st_nxt   = st;
        out_last_nxt = 1'b1;
      end
    end else if (ctrl_cmd.step) begin
      // further read out elements
      out_vld_nxt  = 1'b1;
      out_data_nxt = cells_r[idx_r];
      out_st_nxt   = ST_OK;
      out_last_nxt = dp_sts.at_last;
      idx_nxt      = idx_r + IDX_W'(1);
    end

    out_cnt_nxt = CNT_OUT_W'(count_nxt);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_r[i] <= cells_nxt[i];
    end
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
    if (ctrl_cmd.accept || ctrl_cmd.step) out_cnt_r <= out_cnt_nxt;
  end

  // output packing
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W - VAL_W - CNT_OUT_W){1'b0}}, out_cnt_r, out_data_r};
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

endmodule

// File: rtl/positional_ordered_list_core.sv
// positional ordered list core: insert, delete and ordered read out
// each result is registered and offered in the cycle after its input transfer
// throughput: one insert or delete per cycle while the result side takes each result;
//   a read out emits its elements one by one (one output register, input held off meanwhile)
// reset: synchronous active-low rst_n empties the list and clears the output
// depends on pol_pkg, pol_ctrl and pol_dp
module positional_ordered_list_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [pol_pkg::IN_TDATA_W-1:0]  in_tdata,   // position[4:0], value[36:5]
  input  logic [pol_pkg::CMD_W-1:0]       in_tuser,   // cmd[2:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pol_pkg::OUT_TDATA_W-1:0] out_tdata,  // data[31:0], element_count[36:32]
  output logic [pol_pkg::STATUS_W-1:0]    out_tuser,  // status[1:0]
  output logic                            out_tlast   // last
);
  import pol_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_sts_t   dp_sts;

  // sequencing
  pol_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .dp_sts    (dp_sts),
    .ctrl_cmd  (ctrl_cmd)
  );

  // list storage and results
  pol_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .ctrl_cmd   (ctrl_cmd),
    .dp_sts     (dp_sts)
  );

endmodule

// File: rtl/pol_checker.sv
// port-level checks for the positional ordered list core
// depends on pol_pkg; bound to positional_ordered_list_core below
module pol_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pol_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [pol_pkg::STATUS_W-1:0]    out_tuser,
  input logic                            out_tlast
);
  import pol_pkg::*;

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // input transfer only while the result side has room
  a_in_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !out_tvalid || out_tready)
    else $error("input transfer with a blocked result");

  // element count never exceeds capacity
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[36:32] <= CNT_OUT_W'(CAPACITY))
    else $error("element count above capacity");

  // full status only with a full list
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FULL |-> out_tdata[36:32] == CNT_OUT_W'(CAPACITY))
    else $error("full status with spare room");

  // a result that is not last belongs to a read out and carries ok
  a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser == ST_OK)
    else $error("non-final result with error status");

endmodule

bind positional_ordered_list_core pol_checker u_pol_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// File: tb/positional_ordered_list_core_test.sv
// self-checking testbench for positional_ordered_list_core: directed and random command streams
// with random idling on both stream sides, checked against an in-bench list predictor
// depends on pol_pkg and the positional_ordered_list_core rtl
module positional_ordered_list_core_test;
  import pol_pkg::*;

  localparam int RANDOM_ITEMS = 300;
  localparam int PHASE_LEN    = 40;
  localparam int DRAIN_CYCLES = 20;
  localparam int RUN_LIMIT    = 600000;
  localparam int REPORT_MAX   = 10;

  // one expected result of the list
  typedef struct {
    logic [VAL_W-1:0]     data;
    logic [STATUS_W-1:0]  status;
    logic [CNT_OUT_W-1:0] cnt;
    logic                 last;
  } list_result_t;

  // list predictor and store of pending results
  class list_scoreboard;
    logic [VAL_W-1:0] cells[CAPACITY];
    int               count;
    list_result_t     expected_q[$];
    int               mismatches;

    function new();
      count = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // apply one accepted command and queue the results it causes
    function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                               logic [VAL_W-1:0] val);
      list_result_t res;
      status_t      st;
      int           p;
      int           i;
      int           idx;
      p = pos;
      st = ST_OK;
      idx = -1;
      if (cmd == CMD_READ) begin
        if (count == 0) begin
          res = '{data: '0, status: ST_EMPTY, cnt: '0, last: 1'b1};
          expected_q.push_back(res);
        end else begin
          for (i = 0; i < count; i++) begin
            res = '{data: cells[i], status: ST_OK, cnt: count[CNT_OUT_W-1:0],
                    last: (i == count - 1)};
            expected_q.push_back(res);
          end
        end
        return;
      end
      case (cmd)
        CMD_INSERT: begin
          if (p < 1 || p > count + 1) st = ST_BADPOS;
          else if (count >= CAPACITY) st = ST_FULL;
          else begin
            for (i = count; i > p - 1; i--) cells[i] = cells[i-1];
            cells[p-1] = val;
            count++;
          end
        end
        CMD_DEL_FST, CMD_DEL_LST, CMD_DEL_POS: begin
          if (count == 0) st = ST_EMPTY;
          else if (cmd == CMD_DEL_FST) idx = 0;
          else if (cmd == CMD_DEL_LST) idx = count - 1;
          else if (p < 1 || p > count) st = ST_BADPOS;
          else idx = p - 1;
          // close the gap left by the removed element
          if (idx >= 0) begin
            for (i = idx; i + 1 < count; i++) cells[i] = cells[i+1];
            count--;
          end
        end
        default: ;
      endcase
      res = '{data: '0, status: st, cnt: count[CNT_OUT_W-1:0], last: 1'b1};
      expected_q.push_back(res);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(logic [VAL_W-1:0] data, logic [STATUS_W-1:0] status,
                               logic [CNT_OUT_W-1:0] cnt, logic last);
      list_result_t exp_res;
      if (expected_q.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("mismatch: unexpected result data=%h status=%0d count=%0d last=%b",
                   data, status, cnt, last);
        mismatches++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (data !== exp_res.data || status !== exp_res.status ||
          cnt !== exp_res.cnt || last !== exp_res.last) begin
        if (mismatches < REPORT_MAX)
          $display({"mismatch: expected data=%h status=%0d count=%0d last=%b, ",
                    "got data=%h status=%0d count=%0d last=%b"},
                   exp_res.data, exp_res.status, exp_res.cnt, exp_res.last,
                   data, status, cnt, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   out_tlast;

  list_scoreboard sb;
  bit             no_idle = 1'b0;
  int             cycles = 0;

  positional_ordered_list_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int idle_cycles();
    return no_idle ? 0 : $urandom_range(0, 15);
  endfunction

  // mostly random values, with the extremes mixed in
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // offer one command and wait for its transfer
  task automatic send(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_TDATA_W-VAL_W-POS_W){1'b0}}, val, pos};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    sb.note_command(cmd, pos, val);
  endtask

  // random command, leaning towards growing or shrinking the list by phase
  task automatic pick_command(int n, output logic [CMD_W-1:0] cmd,
                              output logic [POS_W-1:0] pos, output logic [VAL_W-1:0] val);
    int r;
    int cnt;
    bit grow;
    cnt  = sb.count;
    grow = ((n / PHASE_LEN) % 2) == 0;
    r    = $urandom_range(0, 99);
    val  = pick_value();
    pos  = POS_W'($urandom_range(0, 31));
    if (r < (grow ? 60 : 20)) begin
      cmd = CMD_INSERT;
      pos = POS_W'($urandom_range(1, cnt + 1));
    end else if (r < (grow ? 68 : 28)) begin
      cmd = CMD_INSERT;
    end else if (r < 80) begin
      case ($urandom_range(0, 2))
        0: cmd = CMD_DEL_FST;
        1: cmd = CMD_DEL_LST;
        default: begin
          cmd = CMD_DEL_POS;
          if (cnt > 0) pos = POS_W'($urandom_range(1, cnt));
        end
      endcase
    end else if (r < 90) begin
      cmd = CMD_READ;
    end else if (r < 95) begin
      cmd = CMD_DEL_POS;
    end else begin
      // unused command codes above positional delete
      cmd = CMD_W'(CMD_DEL_POS + $urandom_range(1, 3));
    end
  endtask

  // result side: random stalls, check every transfer
  initial begin
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = idle_cycles();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      sb.check_result(out_tdata[VAL_W-1:0], out_tuser,
                      out_tdata[VAL_W+CNT_OUT_W-1:VAL_W], out_tlast);
    end
  end

  // stimulus
  initial begin
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int               n;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: read out and every delete
    send(CMD_READ, 5'd0, '0);
    send(CMD_DEL_FST, 5'd0, '0);
    send(CMD_DEL_LST, 5'd0, '0);
    send(CMD_DEL_POS, 5'd1, '0);
    // insert positions out of range
    send(CMD_INSERT, 5'd0, 32'h1234_5678);
    send(CMD_INSERT, 5'd2, 32'h1234_5678);
    // extremes, insert at end, front and middle
    send(CMD_INSERT, 5'd1, 32'h8000_0000);
    send(CMD_INSERT, 5'd2, 32'h7fff_ffff);
    send(CMD_INSERT, 5'd1, '1);
    send(CMD_INSERT, 5'd2, '0);
    send(CMD_READ, 5'd0, '0);
    // positional delete out of range, then each delete kind
    send(CMD_DEL_POS, 5'd0, '0);
    send(CMD_DEL_POS, 5'd5, '0);
    send(CMD_DEL_POS, 5'd31, '0);
    send(CMD_DEL_POS, 5'd2, '0);
    send(CMD_DEL_FST, 5'd0, '0);
    send(CMD_DEL_LST, 5'd0, '0);
    // unused command codes
    send(CMD_DEL_POS + 3'd1, 5'd3, $urandom);
    send(CMD_DEL_POS + 3'd2, 5'd1, $urandom);
    send(CMD_DEL_POS + 3'd3, 5'd17, $urandom);
    send(CMD_READ, 5'd0, '0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick_command(n, cmd, pos, val);
      send(cmd, pos, val);
    end
    in_tvalid <= 1'b0;

    // drain
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/pol_pkg.sv
rtl/pol_ctrl.sv
rtl/pol_dp.sv
rtl/positional_ordered_list_core.sv
rtl/pol_checker.sv
tb/positional_ordered_list_core_test.sv
